/* design/suti_pkg.sv */
package suti_pkg;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int MAG_W   = 29;
    localparam int COMP_W  = 30;
    localparam int SQ_IN_W = 60;
    localparam int ROOT_W  = 30;
    localparam int XY_W    = 32;
    localparam int ANGLE_W = 34;
    localparam int UV_W    = 16;
    localparam int COL_W   = 12;
    localparam int IDX_W   = 24;

    localparam logic [UV_W-1:0] UV_HALF = 16'h8000;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef struct packed {
        logic             zero;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } side_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] sx;
        logic signed [COMP_W-1:0] sy;
        logic signed [COMP_W-1:0] sz;
    } dir_t;

    typedef struct packed {
        dir_t  dir;
        side_t side;
    } sq_pay_t;

    typedef struct packed {
        logic [ROOT_W-1:0]        root;
        logic signed [COMP_W-1:0] sy;
        side_t                    side;
    } lon_pay_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] lon;
        side_t                     side;
    } lat_pay_t;

    // Angle of atan(2^-i) in units of 2^32 per full turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input int i);
        logic [ANGLE_W-1:0] a;
        case (i)
            0:       a = 34'd536870912;
            1:       a = 34'd316933406;
            2:       a = 34'd167458907;
            3:       a = 34'd85004756;
            4:       a = 34'd42667331;
            5:       a = 34'd21354465;
            6:       a = 34'd10679838;
            7:       a = 34'd5340245;
            8:       a = 34'd2670163;
            9:       a = 34'd1335087;
            10:      a = 34'd667544;
            11:      a = 34'd333772;
            12:      a = 34'd166886;
            13:      a = 34'd83443;
            14:      a = 34'd41722;
            15:      a = 34'd20861;
            16:      a = 34'd10430;
            17:      a = 34'd5215;
            18:      a = 34'd2608;
            19:      a = 34'd1304;
            20:      a = 34'd652;
            21:      a = 34'd326;
            22:      a = 34'd163;
            23:      a = 34'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/suti_front.sv */
module suti_front
    import suti_pkg::*;
#(
    parameter int MAX_TEX_DIM = 4096
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] hit_x,
    input  logic signed [COORD_W-1:0] hit_y,
    input  logic signed [COORD_W-1:0] hit_z,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] center_z,
    input  logic [DIM_W-1:0]          tex_width,
    input  logic [DIM_W-1:0]          tex_height,
    output logic                      out_valid,
    output logic [SQ_IN_W-1:0]        out_n,
    output dir_t                      out_dir,
    output side_t                     out_side
);

    localparam int NSTAGE = 6;
    localparam int SH_W = DIFF_W + MAG_W;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_TEX_DIM);
    localparam logic [5:0] TOP_BIT = 6'(MAG_W - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_MAX)
            r = DIM_MAX;
        else
            r = d;
        return r;
    endfunction

    // Shift a magnitude so that the largest one has its leading one at TOP_BIT.
    function automatic logic [MAG_W-1:0] norm(input logic [DIFF_W-1:0] a, input logic [5:0] p);
        logic [SH_W-1:0] t;
        if (p > TOP_BIT)
            t = SH_W'(a >> (p - TOP_BIT));
        else
            t = SH_W'(a) << (TOP_BIT - p);
        return t[MAG_W-1:0];
    endfunction

    logic [NSTAGE-1:0] vld_reg;
    logic [DIM_W-1:0]  w_reg [1:NSTAGE];
    logic [DIM_W-1:0]  h_reg [1:NSTAGE];

    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [DIFF_W-1:0] ax2_reg, ay2_reg, az2_reg;
    logic [2:0] sgn2_reg, sgn3_reg, sgn4_reg;
    logic [DIFF_W-1:0] ax3_reg, ay3_reg, az3_reg;
    logic [5:0] pos3_reg;
    logic zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [MAG_W-1:0] ax4_reg, ay4_reg, az4_reg;
    logic signed [COMP_W-1:0] sx5_reg, sy5_reg, sz5_reg, sx6_reg, sy6_reg, sz6_reg;
    logic [2*MAG_W-1:0] sqx5_reg, sqz5_reg;
    logic [SQ_IN_W-1:0] n6_reg;

    logic [DIFF_W-1:0] m_next;
    logic [5:0] pos_next;

    always_comb
    begin
        m_next = ax2_reg;
        if (ay2_reg > m_next)
            m_next = ay2_reg;
        if (az2_reg > m_next)
            m_next = az2_reg;
        pos_next = '0;
        for (int k = 0; k < DIFF_W; k++)
        begin
            if (m_next[k])
                pos_next = 6'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx1_reg <= $signed({hit_x[COORD_W-1], hit_x}) - $signed({center_x[COORD_W-1], center_x});
            dy1_reg <= $signed({hit_y[COORD_W-1], hit_y}) - $signed({center_y[COORD_W-1], center_y});
            dz1_reg <= $signed({hit_z[COORD_W-1], hit_z}) - $signed({center_z[COORD_W-1], center_z});
            w_reg[1] <= clamp_dim(tex_width);
            h_reg[1] <= clamp_dim(tex_height);
            for (int k = 2; k <= NSTAGE; k++)
            begin
                w_reg[k] <= w_reg[k-1];
                h_reg[k] <= h_reg[k-1];
            end

            ax2_reg  <= dx1_reg[DIFF_W-1] ? DIFF_W'(-dx1_reg) : DIFF_W'(dx1_reg);
            ay2_reg  <= dy1_reg[DIFF_W-1] ? DIFF_W'(-dy1_reg) : DIFF_W'(dy1_reg);
            az2_reg  <= dz1_reg[DIFF_W-1] ? DIFF_W'(-dz1_reg) : DIFF_W'(dz1_reg);
            sgn2_reg <= {dx1_reg[DIFF_W-1], dy1_reg[DIFF_W-1], dz1_reg[DIFF_W-1]};

            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            az3_reg   <= az2_reg;
            sgn3_reg  <= sgn2_reg;
            pos3_reg  <= pos_next;
            zero3_reg <= (m_next == '0);

            ax4_reg   <= norm(ax3_reg, pos3_reg);
            ay4_reg   <= norm(ay3_reg, pos3_reg);
            az4_reg   <= norm(az3_reg, pos3_reg);
            sgn4_reg  <= sgn3_reg;
            zero4_reg <= zero3_reg;

            sx5_reg   <= sgn4_reg[2] ? -$signed({1'b0, ax4_reg}) : $signed({1'b0, ax4_reg});
            sy5_reg   <= sgn4_reg[1] ? -$signed({1'b0, ay4_reg}) : $signed({1'b0, ay4_reg});
            sz5_reg   <= sgn4_reg[0] ? -$signed({1'b0, az4_reg}) : $signed({1'b0, az4_reg});
            sqx5_reg  <= ax4_reg * ax4_reg;
            sqz5_reg  <= az4_reg * az4_reg;
            zero5_reg <= zero4_reg;

            sx6_reg   <= sx5_reg;
            sy6_reg   <= sy5_reg;
            sz6_reg   <= sz5_reg;
            n6_reg    <= SQ_IN_W'(sqx5_reg) + SQ_IN_W'(sqz5_reg);
            zero6_reg <= zero5_reg;
        end
    end

    assign out_valid     = vld_reg[NSTAGE-1];
    assign out_n         = n6_reg;
    assign out_dir.sx    = sx6_reg;
    assign out_dir.sy    = sy6_reg;
    assign out_dir.sz    = sz6_reg;
    assign out_side.zero = zero6_reg;
    assign out_side.w    = w_reg[NSTAGE];
    assign out_side.h    = h_reg[NSTAGE];

    // After normalization the largest magnitude has its top bit set.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && !zero4_reg |-> (ax4_reg[MAG_W-1] | ay4_reg[MAG_W-1] | az4_reg[MAG_W-1]))
        else $error("normalized direction lost its leading one");

endmodule

/* design/suti_isqrt.sv */
module suti_isqrt
    import suti_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [SQ_IN_W-1:0] in_n,
    input  logic [PW-1:0]      in_pay,
    output logic               out_valid,
    output logic [ROOT_W-1:0]  out_root,
    output logic [PW-1:0]      out_pay
);

    localparam int REM_W = ROOT_W + 3;

    logic [SQ_IN_W-1:0] n_reg    [0:ROOT_W];
    logic [REM_W-1:0]   rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]  root_reg [0:ROOT_W];
    logic [PW-1:0]      pay_reg  [0:ROOT_W];
    logic [ROOT_W:1]    vld_reg;

    assign n_reg[0]    = in_n;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign pay_reg[0]  = in_pay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[ROOT_W-1:1], in_valid};
    end

    // One result bit per stage, two radicand bits brought in from the top.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_bit
        logic [REM_W-1:0]  rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            rem_sh = {rem_reg[k][REM_W-3:0], n_reg[k][SQ_IN_W-1 -: 2]};
            trial  = REM_W'({root_reg[k], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                n_reg[k+1]    <= {n_reg[k][SQ_IN_W-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                pay_reg[k+1]  <= pay_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_pay   = pay_reg[ROOT_W];

endmodule

/* design/suti_cordic.sv */
module suti_cordic
    import suti_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int PW    = 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [XY_W-1:0]    in_x,
    input  logic signed [XY_W-1:0]    in_y,
    input  logic [PW-1:0]             in_pay,
    output logic                      out_valid,
    output logic signed [ANGLE_W-1:0] out_z,
    output logic [PW-1:0]             out_pay
);

    logic signed [XY_W-1:0]    x_reg   [0:STEPS];
    logic signed [XY_W-1:0]    y_reg   [0:STEPS];
    logic signed [ANGLE_W-1:0] z_reg   [0:STEPS];
    logic [PW-1:0]             pay_reg [0:STEPS];
    logic [STEPS:0]            vld_reg;

    logic signed [XY_W-1:0]    x0_next, y0_next;
    logic signed [ANGLE_W-1:0] z0_next;

    // A vector in the left half plane is first turned by a quarter turn.
    always_comb
    begin
        x0_next = in_x;
        y0_next = in_y;
        z0_next = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = QUARTER_TURN;
            end
            else
            begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic signed [ANGLE_W-1:0] ANG = atan_turn(k);
        logic signed [XY_W-1:0]    xs, ys, x_next, y_next;
        logic signed [ANGLE_W-1:0] z_next;

        always_comb
        begin
            xs     = x_reg[k] >>> k;
            ys     = y_reg[k] >>> k;
            x_next = x_reg[k];
            y_next = y_reg[k];
            z_next = z_reg[k];
            if (y_reg[k] > 0)
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + ANG;
            end
            else if (y_reg[k] < 0)
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[k+1]   <= x_next;
                y_reg[k+1]   <= y_next;
                z_reg[k+1]   <= z_next;
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_z     = z_reg[STEPS];
    assign out_pay   = pay_reg[STEPS];

endmodule

/* design/suti_back.sv */
module suti_back
    import suti_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [ANGLE_W-1:0] lon,
    input  logic signed [ANGLE_W-1:0] lat,
    input  side_t                     side,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          out_index,
    output logic [UV_W-1:0]           out_u,
    output logic [UV_W-1:0]           out_v
);

    localparam logic signed [ANGLE_W-1:0] LON_RND = 34'sd32768;
    localparam logic signed [ANGLE_W-1:0] LAT_RND = 34'sd16384;
    localparam logic signed [ANGLE_W-1:0] HALF_S  = 34'sd32768;
    localparam logic signed [ANGLE_W-1:0] SAT_MAX = 34'sd65535;

    function automatic logic [UV_W-1:0] sat16(input logic signed [ANGLE_W-1:0] a);
        logic [UV_W-1:0] r;
        if (a < 0)
            r = '0;
        else if (a > SAT_MAX)
            r = '1;
        else
            r = a[UV_W-1:0];
        return r;
    endfunction

    logic [2:0] vld_reg;
    logic [UV_W-1:0] u1_reg, v1_reg, u2_reg, v2_reg, u3_reg, v3_reg;
    logic [DIM_W-1:0] w1_reg, h1_reg, w2_reg, h2_reg;
    logic zero1_reg;
    logic [COL_W-1:0] col2_reg, row2_reg;
    logic [IDX_W-1:0] idx3_reg;

    logic signed [ANGLE_W-1:0] fu, fv;
    logic [UV_W-1:0] u_next, v_next;
    logic [UV_W+DIM_W-1:0] cp, rp;
    logic [DIM_W-1:0] wm1, hm1;
    logic [COL_W-1:0] col_next, row_next;
    logic [COL_W+DIM_W-1:0] idx_full;

    always_comb
    begin
        fu = (lon + LON_RND) >>> 16;
        fv = (lat + LAT_RND) >>> 15;
        if (side.zero)
        begin
            u_next = UV_HALF;
            v_next = UV_HALF;
        end
        else
        begin
            u_next = sat16(HALF_S - fu);
            v_next = sat16(HALF_S - fv);
        end
    end

    // Scale to texel units, then clamp the edge case of a coordinate of one.
    always_comb
    begin
        cp  = u1_reg * w1_reg;
        rp  = v1_reg * h1_reg;
        wm1 = w1_reg - DIM_W'(1);
        hm1 = h1_reg - DIM_W'(1);
        col_next = cp[UV_W+COL_W-1:UV_W];
        row_next = rp[UV_W+COL_W-1:UV_W];
        if ({1'b0, col_next} > wm1)
            col_next = wm1[COL_W-1:0];
        if ({1'b0, row_next} > hm1)
            row_next = hm1[COL_W-1:0];
    end

    assign idx_full = row2_reg * w2_reg + (COL_W+DIM_W)'(col2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u1_reg    <= u_next;
            v1_reg    <= v_next;
            w1_reg    <= side.w;
            h1_reg    <= side.h;
            zero1_reg <= side.zero;

            u2_reg   <= u1_reg;
            v2_reg   <= v1_reg;
            w2_reg   <= w1_reg;
            h2_reg   <= h1_reg;
            col2_reg <= col_next;
            row2_reg <= row_next;

            u3_reg   <= u2_reg;
            v3_reg   <= v2_reg;
            idx3_reg <= idx_full[IDX_W-1:0];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_index = idx3_reg;
    assign out_u     = u3_reg;
    assign out_v     = v3_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> ({1'b0, col2_reg} < w2_reg))
        else $error("column index beyond texture width");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> ({1'b0, row2_reg} < h2_reg))
        else $error("row index beyond texture height");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && zero1_reg |-> (u1_reg == UV_HALF) && (v1_reg == UV_HALF))
        else $error("degenerate direction did not map to the texture center");

endmodule

/* design/sphere_uv_texel_index.sv */
// Equirectangular texel lookup for a ray that hit a sphere.
// Each input transaction on the s_axis channel carries a hit point, the
// sphere center (signed Q16.16) and the texture size. For each one the block
// returns exactly one m_axis transaction with the row-major texel index and
// the u and v coordinates as unsigned Q0.16 fractions.
// The pipeline is a normalizing front end (6 stages), a radix-4 square root
// (30 stages), a longitude CORDIC and a latitude CORDIC (CORDIC_STEPS + 1
// stages each) and a scaling back end (3 stages). One transaction is accepted
// in every cycle while the output side takes results.
// Reset clears only the valid bits; no result is pending afterwards.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds in place and s_axis_tready drops; nothing is lost or sent
// twice, and the flow resumes at the first edge at which tready is high again.
module sphere_uv_texel_index
    import suti_pkg::*;
#(
    parameter int MAX_TEX_DIM  = 4096,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // hit_x, hit_y, hit_z, center_x, center_y, center_z (32 each),
    // tex_width, tex_height (13 each), zero fill
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // texel_index (24), u_coord (16), v_coord (16)
    output logic [55:0]  m_axis_tdata
);

    logic advance;

    logic signed [COORD_W-1:0] hit_x, hit_y, hit_z, center_x, center_y, center_z;
    logic [DIM_W-1:0] tex_width, tex_height;

    logic               fr_valid;
    logic [SQ_IN_W-1:0] fr_n;
    sq_pay_t            fr_pay;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_pay_t           sq_pay;

    logic signed [XY_W-1:0] lon_x, lon_y, lat_x, lat_y;
    lon_pay_t lon_in_pay, lon_out_pay;
    logic lon_valid;
    logic signed [ANGLE_W-1:0] lon_z;

    lat_pay_t lat_in_pay, lat_out_pay;
    logic lat_valid;
    logic signed [ANGLE_W-1:0] lat_z;

    logic [IDX_W-1:0] texel_index;
    logic [UV_W-1:0]  u_coord, v_coord;

    // The pipeline moves as one whenever the output register is free or
    // being emptied in this cycle.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    assign hit_x      = $signed(s_axis_tdata[31:0]);
    assign hit_y      = $signed(s_axis_tdata[63:32]);
    assign hit_z      = $signed(s_axis_tdata[95:64]);
    assign center_x   = $signed(s_axis_tdata[127:96]);
    assign center_y   = $signed(s_axis_tdata[159:128]);
    assign center_z   = $signed(s_axis_tdata[191:160]);
    assign tex_width  = s_axis_tdata[204:192];
    assign tex_height = s_axis_tdata[217:205];

    suti_front #(
        .MAX_TEX_DIM (MAX_TEX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (s_axis_tvalid && s_axis_tready),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .tex_width  (tex_width),
        .tex_height (tex_height),
        .out_valid  (fr_valid),
        .out_n      (fr_n),
        .out_dir    (fr_pay.dir),
        .out_side   (fr_pay.side)
    );

    // Horizontal radius of the normalized direction.
    suti_isqrt #(
        .PW ($bits(sq_pay_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (fr_valid),
        .in_n      (fr_n),
        .in_pay    (fr_pay),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pay   (sq_pay)
    );

    // Longitude is atan2(-dz, dx).
    assign lon_x           = XY_W'(sq_pay.dir.sx);
    assign lon_y           = -XY_W'(sq_pay.dir.sz);
    assign lon_in_pay.root = sq_root;
    assign lon_in_pay.sy   = sq_pay.dir.sy;
    assign lon_in_pay.side = sq_pay.side;

    suti_cordic #(
        .STEPS (CORDIC_STEPS),
        .PW    ($bits(lon_pay_t))
    ) u_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sq_valid),
        .in_x      (lon_x),
        .in_y      (lon_y),
        .in_pay    (lon_in_pay),
        .out_valid (lon_valid),
        .out_z     (lon_z),
        .out_pay   (lon_out_pay)
    );

    // Latitude is atan2(dy, radius), the same angle as asin(dy / |d|).
    assign lat_x           = $signed({2'b00, lon_out_pay.root});
    assign lat_y           = XY_W'(lon_out_pay.sy);
    assign lat_in_pay.lon  = lon_z;
    assign lat_in_pay.side = lon_out_pay.side;

    suti_cordic #(
        .STEPS (CORDIC_STEPS),
        .PW    ($bits(lat_pay_t))
    ) u_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (lon_valid),
        .in_x      (lat_x),
        .in_y      (lat_y),
        .in_pay    (lat_in_pay),
        .out_valid (lat_valid),
        .out_z     (lat_z),
        .out_pay   (lat_out_pay)
    );

    suti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (lat_valid),
        .lon       (lat_out_pay.lon),
        .lat       (lat_z),
        .side      (lat_out_pay.side),
        .out_valid (m_axis_tvalid),
        .out_index (texel_index),
        .out_u     (u_coord),
        .out_v     (v_coord)
    );

    assign m_axis_tdata = {v_coord, u_coord, texel_index};

endmodule
